FILE: sv/cfx_pkg.sv
// Shared types and constants for the complex FIR low-pass filter.
package cfx_pkg;

    localparam int MAX_TAPS  = 64;
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 16;
    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = 7;
    localparam int INDEX_W   = 6;
    localparam int PROD_W    = SAMPLE_W + COEFF_W;
    localparam int ACC_W     = PROD_W + TAP_AW;
    localparam int DELAY_W   = 2 * SAMPLE_W;

    localparam logic [TAP_CNT_W-1:0] TAP_CNT_MAX = TAP_CNT_W'(MAX_TAPS);
    localparam logic [TAP_CNT_W-1:0] TAP_CNT_MIN = TAP_CNT_W'(1);

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic [INDEX_W-1:0]         coeff_index;
        logic signed [COEFF_W-1:0]  coeff_value;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_re;
        logic signed [SAMPLE_W-1:0] out_im;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic last;
    } mac_ctrl_t;

endpackage

FILE: sv/complex_fir_lowpass_filter.sv
// Top level: sequencer over the delay-line and tap memories, with the output register.
// A sample's result passes the memory read, product and accumulator registers, then
// the drain and emit states into the output register (emit waits out rsp_stall).
// A new request is taken only in idle; the single multiply-accumulate pass reads one
// delay-line entry and one tap per cycle. A coefficient load gives no result.
// Reset clears the delay line and taps (per-entry valid bits), the write position,
// and sets the tap count to 64; no clearing pass is needed.
module complex_fir_lowpass_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  cfx_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output cfx_pkg::rsp_t                       rsp,
    input  logic                                cfg_wr_en,
    input  logic [cfx_pkg::TAP_CNT_W-1:0]       cfg_wr_data
);

    localparam int AW = cfx_pkg::TAP_AW;
    localparam int NW = cfx_pkg::TAP_CNT_W;

    cfx_pkg::state_t     state_reg;
    cfx_pkg::state_t     state_next;
    logic [NW-1:0]       tap_count_reg;
    logic [NW-1:0]       tap_count_next;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       wp_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic                rsp_valid_reg;
    cfx_pkg::rsp_t       rsp_reg;

    logic                req_xfer;
    logic                sample_xfer;
    logic                coeff_xfer;
    logic [AW-1:0]       wp_eff;
    logic [NW-1:0]       n_minus1;
    logic                last;
    logic                load_rsp;
    cfx_pkg::mac_ctrl_t  mac_ctrl;

    logic [cfx_pkg::DELAY_W-1:0]       delay_rd;
    logic [cfx_pkg::COEFF_W-1:0]       tap_rd;
    logic signed [cfx_pkg::SAMPLE_W-1:0] d_re;
    logic signed [cfx_pkg::SAMPLE_W-1:0] d_im;
    logic signed [cfx_pkg::COEFF_W-1:0]  tap_val;
    logic                              mac_done;
    logic signed [cfx_pkg::SAMPLE_W-1:0] res_re;
    logic signed [cfx_pkg::SAMPLE_W-1:0] res_im;

    assign req_stall   = (state_reg != cfx_pkg::ST_IDLE);
    assign req_xfer    = req_valid && !req_stall;
    assign sample_xfer = req_xfer && (req.op == cfx_pkg::OP_FILTER);
    assign coeff_xfer  = req_xfer && (req.op == cfx_pkg::OP_LOAD);

    assign n_minus1 = tap_count_reg - NW'(1);
    assign wp_eff   = ({1'b0, wp_reg} >= tap_count_reg) ? '0 : wp_reg;
    assign last     = ({1'b0, idx_reg} == n_minus1);

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            tap_count_next = cfx_pkg::TAP_CNT_MIN;
        end
        else if (cfg_wr_data > cfx_pkg::TAP_CNT_MAX)
        begin
            tap_count_next = cfx_pkg::TAP_CNT_MAX;
        end
        else
        begin
            tap_count_next = cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        mac_ctrl   = '0;
        load_rsp   = 1'b0;
        unique case (state_reg)
            cfx_pkg::ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next     = cfx_pkg::ST_RUN;
                    idx_next       = '0;
                    pos_next       = wp_eff;
                    mac_ctrl.clear = 1'b1;
                    wp_next        = (({1'b0, wp_eff} + NW'(1)) == tap_count_reg) ?
                                     '0 : wp_eff + AW'(1);
                end
            end
            cfx_pkg::ST_RUN:
            begin
                // walk back through the ring from the newest sample
                mac_ctrl.issue = 1'b1;
                mac_ctrl.last  = last;
                idx_next       = idx_reg + AW'(1);
                pos_next       = (pos_reg == '0) ? n_minus1[AW-1:0] : pos_reg - AW'(1);
                if (last)
                begin
                    state_next = cfx_pkg::ST_DRAIN;
                end
            end
            cfx_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = cfx_pkg::ST_EMIT;
                end
            end
            cfx_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp   = 1'b1;
                    state_next = cfx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfx_pkg::ST_IDLE;
            tap_count_reg <= cfx_pkg::TAP_CNT_MAX;
            wp_reg        <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            if (cfg_wr_en)
            begin
                tap_count_reg <= tap_count_next;
                wp_reg        <= '0;
            end
            else
            begin
                wp_reg <= wp_next;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg.out_re <= res_re;
            rsp_reg.out_im <= res_im;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    cfx_ram #(
        .WIDTH (cfx_pkg::DELAY_W),
        .DEPTH (cfx_pkg::MAX_TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sample_xfer),
        .wr_addr (wp_eff),
        .wr_data ({req.sample_re, req.sample_im}),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (pos_reg),
        .rd_data (delay_rd)
    );

    cfx_ram #(
        .WIDTH (cfx_pkg::COEFF_W),
        .DEPTH (cfx_pkg::MAX_TAPS)
    ) u_tap_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (coeff_xfer),
        .wr_addr (req.coeff_index),
        .wr_data (req.coeff_value),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (idx_reg),
        .rd_data (tap_rd)
    );

    assign d_re    = delay_rd[cfx_pkg::DELAY_W-1:cfx_pkg::SAMPLE_W];
    assign d_im    = delay_rd[cfx_pkg::SAMPLE_W-1:0];
    assign tap_val = tap_rd;

    cfx_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .d_re   (d_re),
        .d_im   (d_im),
        .tap    (tap_val),
        .done   (mac_done),
        .res_re (res_re),
        .res_im (res_im)
    );

    a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wp_reg} < tap_count_reg))
        else $error("write position outside the ring");

    a_tap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_count_reg != '0) && (tap_count_reg <= cfx_pkg::TAP_CNT_MAX))
        else $error("tap count out of range");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfx_pkg::ST_RUN) |-> ({1'b0, idx_reg} < tap_count_reg))
        else $error("tap index past tap count");

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == cfx_pkg::ST_DRAIN))
        else $error("accumulator finished outside drain");

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == cfx_pkg::ST_EMIT))
        else $error("result presented without an emit step");

endmodule

FILE: sv/cfx_ram.sv
// Synchronous single-write, single-read memory with per-entry valid bits that read as zero.
module cfx_ram #(
    parameter int WIDTH = cfx_pkg::DELAY_W,
    parameter int DEPTH = cfx_pkg::MAX_TAPS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: sv/cfx_mac.sv
// Multiply-accumulate pipeline with rounding and saturation of the final sum.
module cfx_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfx_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [cfx_pkg::SAMPLE_W-1:0] d_re,
    input  logic signed [cfx_pkg::SAMPLE_W-1:0] d_im,
    input  logic signed [cfx_pkg::COEFF_W-1:0]  tap,
    output logic                               done,
    output logic signed [cfx_pkg::SAMPLE_W-1:0] res_re,
    output logic signed [cfx_pkg::SAMPLE_W-1:0] res_im
);

    localparam int SW  = cfx_pkg::SAMPLE_W;
    localparam int CW  = cfx_pkg::COEFF_W;
    localparam int PW  = cfx_pkg::PROD_W;
    localparam int AW  = cfx_pkg::ACC_W;
    localparam int QW  = AW - CW + 2;
    localparam logic [AW:0] RND = (AW + 1)'(1) << (CW - 2);

    function automatic logic [SW-1:0] round_sat(input logic [AW-1:0] a);
        logic [AW:0]   r;
        logic [QW-1:0] q;
        r = {a[AW-1], a} + RND;
        q = r[AW:CW-1];
        if ((q[QW-1:SW-1] == '0) || (q[QW-1:SW-1] == '1))
        begin
            return q[SW-1:0];
        end
        else if (q[QW-1])
        begin
            return {1'b1, {(SW - 1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SW - 1){1'b1}}};
        end
    endfunction

    logic                 s0_v_reg;
    logic                 s0_last_reg;
    logic                 s1_v_reg;
    logic                 s1_last_reg;
    logic                 done_reg;
    logic signed [PW-1:0] prod_re_reg;
    logic signed [PW-1:0] prod_im_reg;
    logic [AW-1:0]        acc_re_reg;
    logic [AW-1:0]        acc_im_reg;
    logic [AW-1:0]        acc_re_next;
    logic [AW-1:0]        acc_im_next;

    // control flags follow the registered memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg    <= 1'b0;
            s0_last_reg <= 1'b0;
            s1_v_reg    <= 1'b0;
            s1_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s0_v_reg    <= ctrl.issue;
            s0_last_reg <= ctrl.last;
            s1_v_reg    <= s0_v_reg;
            s1_last_reg <= s0_last_reg;
            done_reg    <= s1_v_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_v_reg)
        begin
            prod_re_reg <= d_re * tap;
            prod_im_reg <= d_im * tap;
        end
    end

    always_comb
    begin
        acc_re_next = acc_re_reg + {{(AW - PW){prod_re_reg[PW-1]}}, prod_re_reg};
        acc_im_next = acc_im_reg + {{(AW - PW){prod_im_reg[PW-1]}}, prod_im_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (s1_v_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign done   = done_reg;
    assign res_re = round_sat(acc_re_reg);
    assign res_im = round_sat(acc_im_reg);

endmodule
